@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned BBA_NUM_BLOCKS = 64;
  localparam int unsigned BBA_MAX_OUT    = 64;
  localparam int unsigned BBA_WORD_W     = 8;
  localparam int unsigned BBA_BIT_W      = $clog2(BBA_WORD_W);

  typedef enum logic [1:0] {
    CMD_ALLOC_CONTIG  = 2'd0,
    CMD_ALLOC_SCATTER = 2'd1,
    CMD_FREE_RANGE    = 2'd2,
    CMD_QUERY         = 2'd3
  } bba_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADARG = 2'd2
  } bba_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND,
    S_RNG_RD,
    S_RNG,
    S_SC_RD,
    S_SC_LD,
    S_SC_PICK,
    S_STAT_RD,
    S_STAT,
    S_RESP,
    S_EMIT_RD,
    S_EMIT
  } bba_state_e;

endpackage

@@ rtl/bba_cmd_if.sv @@
`timescale 1ns / 1ps

interface bba_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] start_block;
  logic [6:0] block_count;

  modport source (output valid, cmd, start_block, block_count, input ready);
  modport sink   (input valid, cmd, start_block, block_count, output ready);
endinterface

@@ rtl/bba_res_if.sv @@
`timescale 1ns / 1ps

interface bba_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] block_index;
  logic       last;
  logic [6:0] free_count;
  logic [6:0] largest_run;

  modport source (output valid, status, block_index, last, free_count, largest_run,
                  input ready);
  modport sink   (input valid, status, block_index, last, free_count, largest_run,
                  output ready);
endinterface

@@ rtl/bba_map_mem.sv @@
`timescale 1ns / 1ps

module bba_map_mem #(
  parameter  int unsigned NUM_WORDS = 8,
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic [bba_pkg::BBA_WORD_W-1:0]     wdata_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic [bba_pkg::BBA_WORD_W-1:0]     rdata_o
);
  import bba_pkg::*;

  logic [BBA_WORD_W-1:0] mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0]  valid_q;

  // a word never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= valid_q[raddr_i] ? mem_q[raddr_i] : '1;
  end

endmodule

@@ rtl/bba_engine.sv @@
`timescale 1ns / 1ps

module bba_engine #(
  parameter  int unsigned NUM_BLOCKS = bba_pkg::BBA_NUM_BLOCKS,
  localparam int unsigned NUM_WORDS  =
    (NUM_BLOCKS + bba_pkg::BBA_WORD_W - 1) / bba_pkg::BBA_WORD_W,
  localparam int unsigned AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bba_cmd_if.sink                        cmd_i,
  bba_res_if.source                      res_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [bba_pkg::BBA_WORD_W-1:0] mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [bba_pkg::BBA_WORD_W-1:0] mem_rdata_i
);
  import bba_pkg::*;

  localparam int unsigned IW         = AW + BBA_BIT_W;
  localparam int unsigned IXW        = IW + 1;
  localparam int unsigned CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned XW         = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam int unsigned PICK_DEPTH = (NUM_BLOCKS < BBA_MAX_OUT) ? NUM_BLOCKS : BBA_MAX_OUT;
  localparam int unsigned PK_W       = $clog2(PICK_DEPTH);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  bba_state_e state_q, state_d;

  logic [AW-1:0]         w_q, w_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IW-1:0]         lo_q, lo_d;
  logic [IW-1:0]         hi_q, hi_d;
  logic                  set_q, set_d;
  logic                  scat_q, scat_d;
  logic [CNT_W-1:0]      racc_q, racc_d;
  logic [CNT_W-1:0]      best_q, best_d;
  logic [CNT_W-1:0]      facc_q, facc_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic [CNT_W-1:0]      run_q, run_d;
  logic [PK_W:0]         k_q, k_d;
  logic [BBA_WORD_W-1:0] cur_q, cur_d;
  bba_status_e           status_q, status_d;
  logic [5:0]            idx_q, idx_d;

  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [5:0]            out_idx_q;
  logic                  out_last_q;
  logic [6:0]            out_free_q;
  logic [6:0]            out_run_q;
  logic                  out_load;
  bba_status_e           out_status;
  logic [5:0]            out_idx;
  logic                  out_last;
  logic                  slot_free;

  logic [5:0]            pick_mem_q [PICK_DEPTH];
  logic [5:0]            pick_rdata_q;
  logic                  pick_we;
  logic [PK_W:0]         pick_raddr;

  // command decode
  bba_cmd_e              cmd_e;
  logic [XW-1:0]         cnt_x, start_x, free_hi_x;
  logic                  bad_arg;
  logic [IW-1:0]         start_iw;

  logic [AW-1:0]         next_w;
  logic [BBA_WORD_W-1:0] real_mask, word_m, rng_mask;
  logic                  find_hit;
  logic [IW-1:0]         find_first;
  logic [CNT_W-1:0]      find_run;
  logic [CNT_W-1:0]      stat_run, stat_best, stat_free;
  logic [BBA_BIT_W-1:0]  low_bit;
  logic [CNT_W-1:0]      k_cnt;

  assign cmd_e     = bba_cmd_e'(cmd_i.cmd);
  assign cnt_x     = XW'(cmd_i.block_count);
  assign start_x   = XW'(cmd_i.start_block);
  assign free_hi_x = start_x + cnt_x - XW'(1);
  assign start_iw  = IW'(cmd_i.start_block);
  assign bad_arg   = (cnt_x == '0) || (cnt_x > XW'(NUM_BLOCKS)) ||
                     ((cmd_e == CMD_ALLOC_SCATTER) && (cnt_x > XW'(BBA_MAX_OUT))) ||
                     ((cmd_e == CMD_FREE_RANGE) && (start_x + cnt_x > XW'(NUM_BLOCKS)));

  assign next_w    = (w_q == LAST_WORD) ? w_q : w_q + AW'(1);
  assign word_m    = mem_rdata_i & real_mask;
  assign k_cnt     = CNT_W'(k_q);
  assign slot_free = !out_valid_q || res_o.ready;

  // blocks past the end of the map count as taken
  always_comb begin
    for (int b = 0; b < BBA_WORD_W; b++) begin
      real_mask[b] = IXW'({w_q, BBA_BIT_W'(b)}) < IXW'(NUM_BLOCKS);
      rng_mask[b]  = ({w_q, BBA_BIT_W'(b)} >= lo_q) && ({w_q, BBA_BIT_W'(b)} <= hi_q);
    end
  end

  // first-fit run search across one word, run length carried between words
  always_comb begin
    logic [CNT_W-1:0] run;
    run        = racc_q;
    find_hit   = 1'b0;
    find_first = '0;
    for (int b = 0; b < BBA_WORD_W; b++) begin
      if (word_m[b]) begin
        run = run + CNT_W'(1);
        if (!find_hit && run == cnt_q) begin
          find_hit   = 1'b1;
          find_first = {w_q, BBA_BIT_W'(b)} + IW'(1) - IW'(cnt_q);
        end
      end else begin
        run = '0;
      end
    end
    find_run = run;
  end

  // free count and longest run, one word per cycle
  always_comb begin
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] best;
    logic [CNT_W-1:0] pop;
    cur  = racc_q;
    best = best_q;
    pop  = '0;
    for (int b = 0; b < BBA_WORD_W; b++) begin
      if (word_m[b]) begin
        cur = cur + CNT_W'(1);
        pop = pop + CNT_W'(1);
        if (cur > best) begin
          best = cur;
        end
      end else begin
        cur = '0;
      end
    end
    stat_run  = cur;
    stat_best = best;
    stat_free = facc_q + pop;
  end

  always_comb begin
    low_bit = '0;
    for (int b = BBA_WORD_W - 1; b >= 0; b--) begin
      if (cur_q[b]) begin
        low_bit = BBA_BIT_W'(b);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    set_d       = set_q;
    scat_d      = scat_q;
    racc_d      = racc_q;
    best_d      = best_q;
    facc_d      = facc_q;
    free_d      = free_q;
    run_d       = run_q;
    k_d         = k_q;
    cur_d       = cur_q;
    status_d    = status_q;
    idx_d       = idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = w_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = w_q;
    pick_we     = 1'b0;
    pick_raddr  = k_q;
    out_load    = 1'b0;
    out_status  = status_q;
    out_idx     = idx_q;
    out_last    = 1'b1;
    cmd_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          idx_d    = '0;
          scat_d   = (cmd_e == CMD_ALLOC_SCATTER);
          w_d      = '0;
          racc_d   = '0;
          k_d      = '0;
          cnt_d    = CNT_W'(cmd_i.block_count);
          status_d = STAT_OK;
          state_d  = S_RESP;
          if (cmd_e != CMD_QUERY) begin
            if (bad_arg) begin
              status_d = STAT_BADARG;
            end else begin
              unique case (cmd_e)
                CMD_ALLOC_CONTIG: begin
                  if (cnt_x > XW'(run_q)) begin
                    status_d = STAT_FULL;
                  end else begin
                    state_d = S_FIND_RD;
                  end
                end
                CMD_ALLOC_SCATTER: begin
                  if (cnt_x > XW'(free_q)) begin
                    status_d = STAT_FULL;
                  end else begin
                    state_d = S_SC_RD;
                  end
                end
                CMD_FREE_RANGE: begin
                  lo_d    = start_iw;
                  hi_d    = IW'(free_hi_x);
                  set_d   = 1'b1;
                  w_d     = start_iw[IW-1:BBA_BIT_W];
                  state_d = S_RNG_RD;
                end
                CMD_QUERY: begin
                end
              endcase
            end
          end
        end
      end
      S_FIND_RD: begin
        state_d = S_FIND;
      end
      S_FIND: begin
        mem_raddr_o = next_w;
        if (find_hit) begin
          lo_d    = find_first;
          hi_d    = find_first + IW'(cnt_q) - IW'(1);
          set_d   = 1'b0;
          idx_d   = 6'(find_first);
          w_d     = find_first[IW-1:BBA_BIT_W];
          state_d = S_RNG_RD;
        end else begin
          racc_d = find_run;
          w_d    = next_w;
        end
      end
      S_RNG_RD: begin
        state_d = S_RNG;
      end
      S_RNG: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = set_q ? (mem_rdata_i | rng_mask) : (mem_rdata_i & ~rng_mask);
        if (w_q == hi_q[IW-1:BBA_BIT_W]) begin
          w_d     = '0;
          state_d = S_STAT_RD;
        end else begin
          w_d         = next_w;
          mem_raddr_o = next_w;
        end
      end
      S_SC_RD: begin
        state_d = S_SC_LD;
      end
      S_SC_LD: begin
        cur_d   = word_m;
        state_d = S_SC_PICK;
      end
      S_SC_PICK: begin
        // one claimed block per cycle, word written back once drained or once enough blocks are claimed
        if (k_cnt != cnt_q && cur_q != '0) begin
          pick_we = 1'b1;
          cur_d   = cur_q & ~(BBA_WORD_W'(1) << low_bit);
          k_d     = k_q + (PK_W + 1)'(1);
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = cur_q;
          if (k_cnt == cnt_q) begin
            w_d     = '0;
            k_d     = '0;
            state_d = S_STAT_RD;
          end else begin
            w_d         = next_w;
            mem_raddr_o = next_w;
            state_d     = S_SC_LD;
          end
        end
      end
      S_STAT_RD: begin
        racc_d  = '0;
        best_d  = '0;
        facc_d  = '0;
        state_d = S_STAT;
      end
      S_STAT: begin
        mem_raddr_o = next_w;
        if (w_q == LAST_WORD) begin
          free_d  = stat_free;
          run_d   = stat_best;
          state_d = scat_q ? S_EMIT_RD : S_RESP;
        end else begin
          racc_d = stat_run;
          best_d = stat_best;
          facc_d = stat_free;
          w_d    = next_w;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_status = STAT_OK;
          out_idx    = pick_rdata_q;
          out_last   = (k_cnt + CNT_W'(1) == cnt_q);
          k_d        = k_q + (PK_W + 1)'(1);
          pick_raddr = k_q + (PK_W + 1)'(1);
          if (out_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_q         <= '0;
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      set_q       <= 1'b0;
      scat_q      <= 1'b0;
      racc_q      <= '0;
      best_q      <= '0;
      facc_q      <= '0;
      free_q      <= CNT_W'(NUM_BLOCKS);
      run_q       <= CNT_W'(NUM_BLOCKS);
      k_q         <= '0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      w_q      <= w_d;
      cnt_q    <= cnt_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      set_q    <= set_d;
      scat_q   <= scat_d;
      racc_q   <= racc_d;
      best_q   <= best_d;
      facc_q   <= facc_d;
      free_q   <= free_d;
      run_q    <= run_d;
      k_q      <= k_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (out_load) begin
      out_status_q <= out_status;
      out_idx_q    <= out_idx;
      out_last_q   <= out_last;
      out_free_q   <= 7'(free_q);
      out_run_q    <= 7'(run_q);
    end
  end

  // claimed block list of a scattered allocation
  always_ff @(posedge clk_i) begin
    if (pick_we) begin
      pick_mem_q[k_q[PK_W-1:0]] <= 6'({w_q, low_bit});
    end
    pick_rdata_q <= pick_mem_q[pick_raddr[PK_W-1:0]];
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.block_index = out_idx_q;
  assign res_o.last        = out_last_q;
  assign res_o.free_count  = out_free_q;
  assign res_o.largest_run = out_run_q;

endmodule

@@ rtl/bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// First-fit bitmap block allocator.
// cmd_i takes one transaction per command (allocate contiguous, allocate
// scattered, free range, query); res_o returns the results with status, block
// index, last flag, free count and longest free run as they stand after it.
// The free map sits in a one-port-read, one-port-write memory of 8-block words;
// search, range and statistics passes walk it one word per cycle (ceil(NUM_BLOCKS / 8) words).
// Steps from accept to result valid:
//   query or rejected command: straight to the result
//   free range: set the range word by word, then the statistics pass, then the result
//   contiguous: scan to the first fitting run, clear it word by word, then statistics
//   scattered: per word, load it and claim its free blocks one by one until
//              enough are claimed, then the statistics pass; the results
//              then stream out one per cycle while res_o takes them.
// A new command is taken only after the last result of the previous one has
// been written to the output register, so one finished result may still wait
// at res_o while the next command is accepted.
// Reset marks every block free (the memory reads as free until first written)
// and clears the output valid flag; no clearing pass is needed.
// A stalled res_o holds the result; the block waits only when it has a new result to load.

module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::BBA_NUM_BLOCKS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_cmd_if.sink   cmd_i,
  bba_res_if.source res_o
);
  import bba_pkg::*;

  localparam int unsigned NUM_WORDS = (NUM_BLOCKS + BBA_WORD_W - 1) / BBA_WORD_W;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [BBA_WORD_W-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [BBA_WORD_W-1:0] mem_rdata;

  bba_map_mem #(
    .NUM_WORDS (NUM_WORDS)
  ) u_map_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bba_engine #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
